// ===== rtl/core/plr_pkg.sv =====
// Shared types and constants for the point-light radiance core.
// Used by plr_atten_step, plr_dir_div and point_light_radiance_core.
`default_nettype none

package plr_pkg;

  // Fixed-point setup
  localparam int COORD_FRAC_BITS = 16;
  localparam logic [2:0] MAX_POWER = 3'd4;

  // Unit widths
  localparam int MAG_W = 33;             // magnitude of a coordinate difference
  localparam int SUM_W = 66;             // sum of three squared magnitudes
  localparam int DIST_W = 33;            // floor square root of the sum
  localparam int SQRT_STEPS = SUM_W / 2; // one root bit per stage
  localparam int RAD_W = 39;             // radiance working value, below 2^39
  localparam int DIR_QBITS = 15;         // quotient bits of a direction component
  localparam int DIR_ONE_SHIFT = 15;     // 2 * 16384 = 2^15

  // Configuration register indexes
  localparam logic [2:0] REG_LIGHT_X     = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y     = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z     = 3'd2;
  localparam logic [2:0] REG_COLOR_RED   = 3'd3;
  localparam logic [2:0] REG_COLOR_GREEN = 3'd4;
  localparam logic [2:0] REG_COLOR_BLUE  = 3'd5;
  localparam logic [2:0] REG_SCALE       = 3'd6;
  localparam logic [2:0] REG_POWER       = 3'd7;

  // Work carried down the pipeline
  typedef struct packed {
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic [MAG_W-1:0]          mag_z;
    logic                      neg_x;
    logic                      neg_y;
    logic                      neg_z;
    logic [DIST_W-1:0]         distance;
    logic [2:0]                steps;
    logic [2:0][RAD_W-1:0]     rad;
    logic [2:0]                sat;
  } plr_item_t;

  // Finished result
  typedef struct packed {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [31:0] rad_red;
    logic [31:0] rad_green;
    logic [31:0] rad_blue;
    logic        zero_dist;
    logic        sat_flag;
  } plr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/point_light_radiance_core.sv =====
// Point-light shading core: direction to the light and attenuated radiance.
// Depends on plr_pkg, plr_atten_step and plr_dir_div.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+-----------
//   input    | in_valid, in_stall, hit_x/y/z     | in / stall out
//   output   | out_valid, out_stall, dir_*, rad_*| out / stall in
//   config   | cfg_valid, cfg_ready, cfg_index,  | in / ready out
//            | cfg_data                          |
//
// One hit point enters per cycle unless in_stall holds the input back.
// The pipeline is made of two front stages, the 34-stage square root, four 40-stage
// attenuation dividers and the 16-stage direction divider.
// Reset clears all valid bits and the output buffer and restores the registers.
// A two-entry output buffer takes results; the pipeline holds only when full.
`default_nettype none

module point_light_radiance_core
  import plr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z,
  output logic        [31:0] rad_red,
  output logic        [31:0] rad_green,
  output logic        [31:0] rad_blue,
  output logic               zero_dist,
  output logic               sat_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int REM_W = DIST_W + 2;

  // Configuration registers
  logic [31:0] light_x, light_y, light_z;
  logic [15:0] color_red, color_green, color_blue, radiance_scale;
  logic [2:0]  atten_power;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x        <= '0;
      light_y        <= '0;
      light_z        <= '0;
      color_red      <= 16'd32768;
      color_green    <= 16'd32768;
      color_blue     <= 16'd32768;
      radiance_scale <= 16'd256;
      atten_power    <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIGHT_X:     light_x        <= cfg_data;
        REG_LIGHT_Y:     light_y        <= cfg_data;
        REG_LIGHT_Z:     light_z        <= cfg_data;
        REG_COLOR_RED:   color_red      <= cfg_data[15:0];
        REG_COLOR_GREEN: color_green    <= cfg_data[15:0];
        REG_COLOR_BLUE:  color_blue     <= cfg_data[15:0];
        REG_SCALE:       radiance_scale <= cfg_data[15:0];
        REG_POWER:       atten_power    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Output buffer occupancy gates the whole pipeline
  logic [1:0] count;
  logic       en;

  assign en       = count != 2'd2;
  assign in_stall = !en;

  // Stage A: differences, magnitudes, base radiance, clamped power
  plr_item_t a_itm;

  always_comb begin : front
    logic [MAG_W-1:0] dx, dy, dz;
    dx = {light_x[31], light_x} - {hit_x[31], hit_x};
    dy = {light_y[31], light_y} - {hit_y[31], hit_y};
    dz = {light_z[31], light_z} - {hit_z[31], hit_z};
    a_itm = '0;
    a_itm.neg_x = dx[MAG_W-1];
    a_itm.neg_y = dy[MAG_W-1];
    a_itm.neg_z = dz[MAG_W-1];
    a_itm.mag_x = dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
    a_itm.mag_y = dy[MAG_W-1] ? (MAG_W'(0) - dy) : dy;
    a_itm.mag_z = dz[MAG_W-1] ? (MAG_W'(0) - dz) : dz;
    a_itm.rad[0] = RAD_W'(radiance_scale) * RAD_W'(color_red);
    a_itm.rad[1] = RAD_W'(radiance_scale) * RAD_W'(color_green);
    a_itm.rad[2] = RAD_W'(radiance_scale) * RAD_W'(color_blue);
    a_itm.steps = (atten_power > MAX_POWER) ? MAX_POWER : atten_power;
  end

  plr_item_t s1_itm, s2_itm;
  logic      s1_vld, s2_vld;
  logic [2:0][SUM_W-1:0] s2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
    end
  end

  // Stage B: squares
  always_ff @(posedge clk) begin
    if (en) begin
      s1_itm   <= a_itm;
      s2_itm   <= s1_itm;
      s2_sq[0] <= SUM_W'(s1_itm.mag_x) * SUM_W'(s1_itm.mag_x);
      s2_sq[1] <= SUM_W'(s1_itm.mag_y) * SUM_W'(s1_itm.mag_y);
      s2_sq[2] <= SUM_W'(s1_itm.mag_z) * SUM_W'(s1_itm.mag_z);
    end
  end

  // Stage C and square root: two radicand bits per stage
  logic [SQRT_STEPS:0]   sq_vld;
  plr_item_t             sq_itm  [SQRT_STEPS+1];
  logic [SUM_W-1:0]      sq_rad  [SQRT_STEPS+1];
  logic [REM_W-1:0]      sq_rem  [SQRT_STEPS+1];
  logic [DIST_W-1:0]     sq_root [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_itm[0]  <= s2_itm;
      sq_rad[0]  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar i = 1; i <= SQRT_STEPS; i++) begin : g_sqrt
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] df;
    logic             ge;

    assign rs    = {sq_rem[i-1], sq_rad[i-1][SUM_W-1:SUM_W-2]};
    assign trial = {2'b00, sq_root[i-1], 2'b01};
    assign df    = rs - trial;
    assign ge    = rs >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i] <= 1'b0;
      end else if (en) begin
        sq_vld[i] <= sq_vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_itm[i]  <= sq_itm[i-1];
        sq_rad[i]  <= {sq_rad[i-1][SUM_W-3:0], 2'b00};
        sq_rem[i]  <= ge ? df[REM_W-1:0] : rs[REM_W-1:0];
        sq_root[i] <= {sq_root[i-1][DIST_W-2:0], ge};
      end
    end
  end

  // Attenuation: one divider per power step
  logic [MAX_POWER:0] at_vld;
  plr_item_t          at_itm [MAX_POWER+1];

  always_comb begin
    at_itm[0] = sq_itm[SQRT_STEPS];
    at_itm[0].distance = sq_root[SQRT_STEPS];
  end
  assign at_vld[0] = sq_vld[SQRT_STEPS];

  for (genvar k = 0; k < MAX_POWER; k++) begin : g_atten
    plr_atten_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (at_vld[k]),
      .in_item   (at_itm[k]),
      .out_valid (at_vld[k+1]),
      .out_item  (at_itm[k+1])
    );
  end

  // Direction and output formatting
  logic        dv_vld;
  plr_result_t dv_res;

  plr_dir_div u_dir (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (at_vld[MAX_POWER]),
    .in_item   (at_itm[MAX_POWER]),
    .out_valid (dv_vld),
    .out_res   (dv_res)
  );

  // Two-entry output buffer, head in ent0
  plr_result_t ent0, ent1;
  logic        push, pop;

  assign push = en && dv_vld;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) ent0 <= dv_res;
        else ent1 <= dv_res;
      end
      2'b01: begin
        ent0 <= ent1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          ent0 <= dv_res;
        end else begin
          ent0 <= ent1;
          ent1 <= dv_res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = count != 2'd0;
  assign dir_x     = ent0.dir_x;
  assign dir_y     = ent0.dir_y;
  assign dir_z     = ent0.dir_z;
  assign rad_red   = ent0.rad_red;
  assign rad_green = ent0.rad_green;
  assign rad_blue  = ent0.rad_blue;
  assign zero_dist = ent0.zero_dist;
  assign sat_flag  = ent0.sat_flag;

endmodule

`default_nettype wire

// ===== rtl/core/plr_atten_step.sv =====
// One distance attenuation step for all three color channels:
// a saturation check stage, then a restoring divider at one bit per stage.
// Depends on plr_pkg.
`default_nettype none

module plr_atten_step
  import plr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  plr_item_t in_item,
  output logic      out_valid,
  output plr_item_t out_item
);

  localparam int NSTG = RAD_W + 1;
  localparam int REM_W = DIST_W;
  localparam int SH = RAD_W - COORD_FRAC_BITS;
  localparam int CMP_W = DIST_W + SH;

  logic [NSTG-1:0]             vld;
  plr_item_t                   itm [NSTG];
  logic [2:0][REM_W-1:0]       rem [NSTG];
  logic [2:0]                  div [NSTG];

  plr_item_t                   itm0;
  logic [2:0][REM_W-1:0]       rem0;
  logic [2:0]                  div0;

  // Check for saturation and load the dividend
  always_comb begin
    itm0 = in_item;
    rem0 = '0;
    div0 = '0;
    if (in_item.steps != 3'd0) begin
      itm0.steps = in_item.steps - 3'd1;
      for (int c = 0; c < 3; c++) begin
        if (!in_item.sat[c] && in_item.rad[c] != '0) begin
          if (CMP_W'(in_item.rad[c]) >= (CMP_W'(in_item.distance) << SH)) begin
            itm0.sat[c] = 1'b1;
          end else begin
            div0[c] = 1'b1;
            rem0[c] = REM_W'(in_item.rad[c] >> SH);
            itm0.rad[c] = in_item.rad[c] << COORD_FRAC_BITS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm[0] <= itm0;
      rem[0] <= rem0;
      div[0] <= div0;
    end
  end

  // Shift in one dividend bit and produce one quotient bit per stage
  for (genvar i = 1; i < NSTG; i++) begin : g_stage
    plr_item_t             itm_next;
    logic [2:0][REM_W-1:0] rem_next;

    always_comb begin
      logic [REM_W:0] rs;
      logic [REM_W:0] df;
      logic           ge;
      itm_next = itm[i-1];
      rem_next = rem[i-1];
      for (int c = 0; c < 3; c++) begin
        rs = {rem[i-1][c], itm[i-1].rad[c][RAD_W-1]};
        df = rs - {1'b0, itm[i-1].distance};
        ge = rs >= {1'b0, itm[i-1].distance};
        if (div[i-1][c]) begin
          rem_next[c] = ge ? df[REM_W-1:0] : rs[REM_W-1:0];
          itm_next.rad[c] = {itm[i-1].rad[c][RAD_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm[i] <= itm_next;
        rem[i] <= rem_next;
        div[i] <= div[i-1];
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign out_item  = itm[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/core/plr_dir_div.sv =====
// Direction divider: rounds |diff| * 16384 / dist for three axes with a
// one-bit-per-stage restoring divider, then formats the result.
// Depends on plr_pkg.
`default_nettype none

module plr_dir_div
  import plr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  plr_item_t   in_item,
  output logic        out_valid,
  output plr_result_t out_res
);

  localparam int NSTG = DIR_QBITS + 1;
  localparam int NUM_W = MAG_W + DIR_ONE_SHIFT + 1;
  localparam int REM_W = DIST_W + 1;

  logic [NSTG-1:0]             vld;
  plr_item_t                   itm [NSTG];
  logic [2:0][REM_W-1:0]       rem [NSTG];
  logic [2:0][DIR_QBITS-1:0]   quo [NSTG];

  logic [2:0][REM_W-1:0]       rem0;
  logic [2:0][DIR_QBITS-1:0]   quo0;

  // Build the rounded numerator |diff| * 2^15 + dist for each axis
  always_comb begin
    logic [2:0][MAG_W-1:0] mg;
    logic [NUM_W-1:0]      num;
    mg = {in_item.mag_z, in_item.mag_y, in_item.mag_x};
    for (int c = 0; c < 3; c++) begin
      num = (NUM_W'(mg[c]) << DIR_ONE_SHIFT) + NUM_W'(in_item.distance);
      rem0[c] = num[NUM_W-1:DIR_QBITS];
      quo0[c] = num[DIR_QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itm[0] <= in_item;
      rem[0] <= rem0;
      quo[0] <= quo0;
    end
  end

  // Divide by 2 * dist, one quotient bit per stage
  for (genvar i = 1; i < NSTG; i++) begin : g_stage
    logic [2:0][REM_W-1:0]     rem_next;
    logic [2:0][DIR_QBITS-1:0] quo_next;

    always_comb begin
      logic [REM_W:0] rs;
      logic [REM_W:0] dv;
      logic [REM_W:0] df;
      logic           ge;
      dv = {1'b0, itm[i-1].distance, 1'b0};
      for (int c = 0; c < 3; c++) begin
        rs = {rem[i-1][c], quo[i-1][c][DIR_QBITS-1]};
        df = rs - dv;
        ge = rs >= dv;
        rem_next[c] = ge ? df[REM_W-1:0] : rs[REM_W-1:0];
        quo_next[c] = {quo[i-1][c][DIR_QBITS-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        itm[i] <= itm[i-1];
        rem[i] <= rem_next;
        quo[i] <= quo_next;
      end
    end
  end

  // Apply signs, the zero distance case and radiance saturation
  always_comb begin
    plr_item_t          fi;
    logic               zero;
    logic [2:0]         ng;
    logic [2:0][15:0]   dr;
    logic [2:0][31:0]   rd;
    logic [15:0]        m16;
    fi = itm[NSTG-1];
    zero = fi.distance == '0;
    ng = {fi.neg_z, fi.neg_y, fi.neg_x};
    for (int c = 0; c < 3; c++) begin
      m16 = zero ? 16'd0 : {1'b0, quo[NSTG-1][c]};
      dr[c] = ng[c] ? (16'd0 - m16) : m16;
      rd[c] = fi.sat[c] ? 32'hFFFF_FFFF : fi.rad[c][RAD_W-1:RAD_W-32];
    end
    out_res.dir_x     = dr[0];
    out_res.dir_y     = dr[1];
    out_res.dir_z     = dr[2];
    out_res.rad_red   = rd[0];
    out_res.rad_green = rd[1];
    out_res.rad_blue  = rd[2];
    out_res.zero_dist = zero;
    out_res.sat_flag  = |fi.sat;
  end

  assign out_valid = vld[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/core/plr_checker.sv =====
// Port-level checks for point_light_radiance_core, attached by bind.
// Depends only on the core's ports.
`default_nettype none

module plr_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] dir_y,
  input logic signed [15:0] dir_z,
  input logic        [31:0] rad_red,
  input logic        [31:0] rad_green,
  input logic        [31:0] rad_blue,
  input logic               zero_dist,
  input logic               sat_flag
);

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dir_x) && $stable(rad_red)
      && $stable(sat_flag))
    else $error("stalled transaction changed");

  // Zero distance gives a zero direction
  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_dist |-> dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)
    else $error("nonzero direction at zero distance");

  // Saturation shows up in some channel
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_flag |-> rad_red == 32'hFFFF_FFFF || rad_green == 32'hFFFF_FFFF
      || rad_blue == 32'hFFFF_FFFF)
    else $error("saturation flag without saturated channel");

  // Direction stays within unit range
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dir_x <= 16'sd16384 && dir_x >= -16'sd16384
      && dir_y <= 16'sd16384 && dir_y >= -16'sd16384
      && dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
    else $error("direction component out of range");

endmodule

bind point_light_radiance_core plr_port_checks u_plr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .dir_x     (dir_x),
  .dir_y     (dir_y),
  .dir_z     (dir_z),
  .rad_red   (rad_red),
  .rad_green (rad_green),
  .rad_blue  (rad_blue),
  .zero_dist (zero_dist),
  .sat_flag  (sat_flag)
);

`default_nettype wire

// ===== bench/plr_checker.sv =====
// Scoreboard for point_light_radiance_core: tracks register writes, predicts each result.
// Compares every output transaction with the oldest prediction. Depends on plr_pkg.
module plr_checker
  import plr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic signed [31:0] hit_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic        [31:0] rad_red,
  input  logic        [31:0] rad_green,
  input  logic        [31:0] rad_blue,
  input  logic               zero_dist,
  input  logic               sat_flag,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] lx, ly, lz;
  logic [15:0] col_r, col_g, col_b, scale;
  logic [2:0] power;
  plr_result_t shade_q[$];

  // Floor square root of a 66-bit sum, two bits per step
  function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
    logic [32:0] root;
    logic [67:0] rem;
    logic [67:0] trial;
    root = '0;
    rem = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | 68'((v >> (2 * i)) & 66'd3);
      trial = {33'd0, root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  // Direction component in Q1.14, rounded half away from zero
  function automatic logic [15:0] unit_comp(input logic signed [32:0] diff,
                                            input logic [32:0] distance);
    logic [63:0] a, q;
    if (distance == 0) return '0;
    a = diff < 0 ? 64'(-diff) : 64'(diff);
    q = (a * 64'd32768 + 64'(distance)) / (64'(distance) * 2);
    if (q > 16384) q = 16384;
    return diff < 0 ? 16'(-q) : 16'(q);
  endfunction

  // Attenuated radiance for one color channel
  function automatic logic [31:0] atten_channel(input logic [15:0] col,
                                                input logic [32:0] distance,
                                                input int p, inout logic sat);
    logic [63:0] r;
    r = 64'(scale) * 64'(col);
    for (int k = 0; k < p; k++) begin
      if (distance == 0) begin
        if (r == 0) return '0;
        sat = 1'b1;
        return 32'hFFFF_FFFF;
      end
      r = (r << COORD_FRAC_BITS) / 64'(distance);
      if (r >= (64'd1 << RAD_W)) begin
        sat = 1'b1;
        return 32'hFFFF_FFFF;
      end
    end
    return 32'(r >> 7);
  endfunction

  function automatic plr_result_t shade_point(input logic signed [31:0] hx,
                                              input logic signed [31:0] hy,
                                              input logic signed [31:0] hz);
    logic signed [32:0] dx, dy, dz;
    logic [32:0] ax, ay, az, distance;
    logic [65:0] sum;
    logic sat;
    int p;
    plr_result_t res;
    dx = 33'(lx) - 33'(hx);
    dy = 33'(ly) - 33'(hy);
    dz = 33'(lz) - 33'(hz);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
    distance = floor_sqrt(sum);
    p = power > MAX_POWER ? int'(MAX_POWER) : int'(power);
    sat = 1'b0;
    res.dir_x = unit_comp(dx, distance);
    res.dir_y = unit_comp(dy, distance);
    res.dir_z = unit_comp(dz, distance);
    res.rad_red = atten_channel(col_r, distance, p, sat);
    res.rad_green = atten_channel(col_g, distance, p, sat);
    res.rad_blue = atten_channel(col_b, distance, p, sat);
    res.zero_dist = distance == 0;
    res.sat_flag = sat;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = shade_q.size();

  // Track registers, queue predictions, compare results
  always @(posedge clk) begin
    plr_result_t e;
    if (rst) begin
      lx <= '0; ly <= '0; lz <= '0;
      col_r <= 16'd32768; col_g <= 16'd32768; col_b <= 16'd32768;
      scale <= 16'd256; power <= '0;
      shade_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) shade_q.push_back(shade_point(hit_x, hit_y, hit_z));
      if (out_valid && !out_stall) begin
        if (shade_q.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          e = shade_q.pop_front();
          check_field("dir_x", 32'(e.dir_x), 32'(unsigned'(dir_x)));
          check_field("dir_y", 32'(e.dir_y), 32'(unsigned'(dir_y)));
          check_field("dir_z", 32'(e.dir_z), 32'(unsigned'(dir_z)));
          check_field("rad_red", e.rad_red, rad_red);
          check_field("rad_green", e.rad_green, rad_green);
          check_field("rad_blue", e.rad_blue, rad_blue);
          check_field("zero_dist", 32'(e.zero_dist), 32'(zero_dist));
          check_field("sat_flag", 32'(e.sat_flag), 32'(sat_flag));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIGHT_X:     lx <= cfg_data;
          REG_LIGHT_Y:     ly <= cfg_data;
          REG_LIGHT_Z:     lz <= cfg_data;
          REG_COLOR_RED:   col_r <= cfg_data[15:0];
          REG_COLOR_GREEN: col_g <= cfg_data[15:0];
          REG_COLOR_BLUE:  col_b <= cfg_data[15:0];
          REG_SCALE:       scale <= cfg_data[15:0];
          REG_POWER:       power <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top-level bench for point_light_radiance_core: clock, reset, stimulus and verdict.
// Depends on plr_pkg, the core and plr_checker.
module tb
  import plr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] hit_x = 0, hit_y = 0, hit_z = 0;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [31:0] rad_red, rad_green, rad_blue;
  logic zero_dist, sat_flag;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic steady = 0;
  int fail_count, pending;
  logic signed [31:0] cur_x, cur_y, cur_z;

  always #5 clk = ~clk;

  point_light_radiance_core dut (.*);
  plr_checker chk (.*);

  // Stall the result side at random unless in a steady stretch
  always @(posedge clk) out_stall <= steady ? 1'b0 : ($urandom_range(99) < 31);

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain outstanding results before touching registers
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_light(input logic [31:0] x, y, z, input logic [15:0] r, g, b,
                           input logic [15:0] s, input logic [2:0] p);
    drain();
    write_reg(REG_LIGHT_X, x);
    write_reg(REG_LIGHT_Y, y);
    write_reg(REG_LIGHT_Z, z);
    write_reg(REG_COLOR_RED, {16'($urandom_range(65535)), r});
    write_reg(REG_COLOR_GREEN, {16'($urandom_range(65535)), g});
    write_reg(REG_COLOR_BLUE, {16'($urandom_range(65535)), b});
    write_reg(REG_SCALE, {16'($urandom_range(65535)), s});
    write_reg(REG_POWER, {29'($urandom), p});
    cur_x = x; cur_y = y; cur_z = z;
  endtask

  // Offer one hit point, idling at random first
  task automatic send(input logic [31:0] x, y, z);
    if (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    hit_x <= x; hit_y <= y; hit_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_idle_end();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hit point near the light, far away, on it, or anywhere
  task automatic send_random();
    logic [31:0] v[3];
    int kind;
    int span;
    kind = $urandom_range(99);
    span = 1 << $urandom_range(24);
    v[0] = cur_x; v[1] = cur_y; v[2] = cur_z;
    for (int i = 0; i < 3; i++) begin
      if (kind < 5) ;
      else if (kind < 60) v[i] = v[i] + $urandom_range(2 * span) - span;
      else v[i] = $urandom;
    end
    send(v[0], v[1], v[2]);
  endtask

  initial begin
    cur_x = 0; cur_y = 0; cur_z = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default registers, zero distance, axis points, extremes
    send(0, 0, 0);
    send(32'h0001_0000, 0, 0);
    send(0, 32'hFFFF_0000, 0);
    send(0, 0, 1);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(3, 4, 0);
    send(1, 1, 0);
    send_idle_end();
    set_light(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd32768, 16'd0, 16'hFFFF,
              16'hFFFF, 3'd4);
    send(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send(32'h8000_0001, 32'h7FFF_FFFF, 0);
    send(32'h8000_0000, 32'h7FFF_FFFE, 1);
    send_idle_end();
    set_light(0, 0, 0, 16'd1, 16'd32768, 16'd0, 16'd0, 3'd7);
    send(0, 0, 0);
    send(1, 0, 0);
    send(0, 32'h0000_0100, 0);
    send_idle_end();
    set_light(5, -5, 7, 16'd32768, 16'd32768, 16'd32768, 16'hFFFF, 3'd1);
    send(5, -5, 7);
    send(6, -5, 7);
    send(5, -5, 8);
    send_idle_end();

    // Random phases, each with its own light setup
    for (int ph = 0; ph < 8; ph++) begin
      set_light($urandom, $urandom, $urandom, 16'($urandom_range(32768)),
                16'($urandom_range(32768)),
                16'($urandom_range(ph == 3 ? 65535 : 32768)),
                ph == 5 ? 16'd0 : 16'($urandom), 3'(ph));
      steady = (ph == 2);
      for (int n = 0; n < 75; n++) begin
        if (ph == 4 && n == 40) begin
          // Hold off the sender until the pipeline is empty
          send_idle_end();
          while (pending != 0) @(posedge clk);
        end
        send_random();
      end
      send_idle_end();
      steady = 0;
    end

    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/plr_pkg.sv
rtl/core/plr_atten_step.sv
rtl/core/plr_dir_div.sv
rtl/core/point_light_radiance_core.sv
rtl/core/plr_checker.sv
bench/plr_checker.sv
bench/tb.sv
